/* src/gblit_pkg.sv */
// ----------------------------------------------------------------------------
// gblit_pkg
// Shared types, constants and helpers for the glyph blitter.
// ----------------------------------------------------------------------------
package gblit_pkg;

  localparam int MAX_BOX     = 64;
  localparam int SCREEN_MAX  = 1024;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEN_COLOR     = 2'd2;

  localparam logic [6:0]  BOX_CAP    = 7'(MAX_BOX);
  localparam logic [6:0]  LEVEL_FULL = 7'd64;
  localparam logic [6:0]  COUNT_MAX  = 7'd127;
  localparam logic [10:0] SCREEN_CAP = 11'(SCREEN_MAX);

  localparam logic [10:0] RST_SCREEN_WIDTH  = 11'd640;
  localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd480;
  localparam logic [31:0] RST_PEN_COLOR     = 32'hFFFF_FFFF;

  // one glyph byte with its position resolved
  typedef struct packed {
    logic signed [16:0] origin_x;
    logic signed [16:0] origin_y;
    logic [6:0]         col;
    logic [6:0]         row;
    logic [6:0]         width;
    logic [6:0]         height;
    logic [6:0]         level;
  } gblit_pos_t;

  typedef struct packed {
    logic [10:0] screen_width;
    logic [10:0] screen_height;
    logic [31:0] pen_color;
  } gblit_cfg_t;

  function automatic logic [6:0] cap7(input logic [6:0] v, input logic [6:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  // row length rounded up to a multiple of four bytes
  function automatic logic [7:0] pad_width(input logic [6:0] w);
    logic [7:0] sum;
    sum = {1'b0, w} + 8'd3;
    return {sum[7:2], 2'b00};
  endfunction

endpackage

/* src/gblit_track.sv */
// ----------------------------------------------------------------------------
// gblit_track
// Latches the glyph origin and width, walks column and row over the padded
// rows and registers each byte with its position.
// ----------------------------------------------------------------------------
module gblit_track (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_first,
  input  logic signed [15:0]       in_pen_x,
  input  logic signed [15:0]       in_pen_y,
  input  logic signed [7:0]        in_origin_dx,
  input  logic signed [7:0]        in_origin_dy,
  input  logic [6:0]               in_box_width,
  input  logic [6:0]               in_box_height,
  input  logic [6:0]               in_level,
  input  logic                     adv,
  output logic                     pos_valid,
  output gblit_pkg::gblit_pos_t    pos
);
  import gblit_pkg::*;

  logic signed [16:0] origin_x_reg;
  logic signed [16:0] origin_y_reg;
  logic [6:0]         width_reg;
  logic [6:0]         column_count;
  logic [6:0]         row_count;

  logic               accept;
  logic signed [16:0] org_x_cur;
  logic signed [16:0] org_y_cur;
  logic [6:0]         width_cur;
  logic [6:0]         col_cur;
  logic [6:0]         row_cur;
  logic [7:0]         pad;
  logic [7:0]         col_inc;
  logic [6:0]         column_count_next;
  logic [6:0]         row_count_next;

  assign in_ready = !pos_valid || adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (in_first) begin
      org_x_cur = {in_pen_x[15], in_pen_x} + {{9{in_origin_dx[7]}}, in_origin_dx};
      org_y_cur = {in_pen_y[15], in_pen_y} + {{9{in_origin_dy[7]}}, in_origin_dy};
      width_cur = cap7(in_box_width, BOX_CAP);
      col_cur   = '0;
      row_cur   = '0;
    end else begin
      org_x_cur = origin_x_reg;
      org_y_cur = origin_y_reg;
      width_cur = width_reg;
      col_cur   = column_count;
      row_cur   = row_count;
    end
    pad     = pad_width(width_cur);
    col_inc = {1'b0, col_cur} + 8'd1;
    // end of padded row: wrap column, row saturates
    if (col_inc >= pad) begin
      column_count_next = '0;
      row_count_next    = (row_cur < COUNT_MAX) ? row_cur + 7'd1 : row_cur;
    end else begin
      column_count_next = col_inc[6:0];
      row_count_next    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x_reg <= '0;
      origin_y_reg <= '0;
      width_reg    <= '0;
      column_count <= '0;
      row_count    <= '0;
      pos_valid    <= 1'b0;
    end else if (accept) begin
      origin_x_reg <= org_x_cur;
      origin_y_reg <= org_y_cur;
      width_reg    <= width_cur;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      pos_valid    <= 1'b1;
    end else if (adv) begin
      pos_valid    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos.origin_x <= org_x_cur;
      pos.origin_y <= org_y_cur;
      pos.col      <= col_cur;
      pos.row      <= row_cur;
      pos.width    <= width_cur;
      pos.height   <= cap7(in_box_height, BOX_CAP);
      pos.level    <= cap7(in_level, LEVEL_FULL);
    end
  end

  // column always lies inside the padded row of the latched width
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    column_count == 7'd0 || {1'b0, column_count} < pad_width(width_reg))
    else $error("column beyond padded row");

  // a new glyph restarts at column 0 of row 0, so one byte later we sit at
  // column 1, or at the next row for a zero-width box
  a_first_restart: assert property (@(posedge clk) disable iff (rst)
    accept && in_first |=>
      (row_count == 7'd0 && column_count == 7'd1) ||
      (row_count == 7'd1 && column_count == 7'd0))
    else $error("glyph start did not restart position");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(column_count) && $stable(row_count) && $stable(width_reg))
    else $error("position moved without a transaction");

endmodule

/* src/gblit_shade.sv */
// ----------------------------------------------------------------------------
// gblit_shade
// Screen coordinate, clipping and alpha scaling; holds the result register.
// ----------------------------------------------------------------------------
module gblit_shade (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pos_valid,
  input  gblit_pkg::gblit_pos_t    pos,
  input  gblit_pkg::gblit_cfg_t    cfg,
  input  logic                     out_ready,
  output logic                     adv,
  output logic                     out_valid,
  output logic [9:0]               pixel_x,
  output logic [9:0]               pixel_y,
  output logic [31:0]              pixel_color
);
  import gblit_pkg::*;

  logic [10:0]        sw;
  logic [10:0]        sh;
  logic signed [17:0] x;
  logic signed [17:0] y;
  logic               x_in;
  logic               y_in;
  logic               keep;
  logic [14:0]        prod;

  assign adv = !out_valid || out_ready;

  always_comb begin
    sw   = (cfg.screen_width  > SCREEN_CAP) ? SCREEN_CAP : cfg.screen_width;
    sh   = (cfg.screen_height > SCREEN_CAP) ? SCREEN_CAP : cfg.screen_height;
    x    = {pos.origin_x[16], pos.origin_x} + {11'd0, pos.col};
    y    = {pos.origin_y[16], pos.origin_y} + {11'd0, pos.row};
    x_in = !x[17] && (x[16:0] < {6'd0, sw});
    y_in = !y[17] && (y[16:0] < {6'd0, sh});
    keep = (pos.col < pos.width) && (pos.row < pos.height) &&
           (pos.level != 7'd0) && x_in && y_in;
    prod = 15'(cfg.pen_color[31:24]) * 15'(pos.level);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= pos_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pos_valid && keep) begin
      pixel_x     <= x[9:0];
      pixel_y     <= y[9:0];
      pixel_color <= {prod[13:6], cfg.pen_color[23:0]};
    end
  end

  a_rose_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pos_valid))
    else $error("result appeared without an item in flight");

endmodule

/* src/glyph_blit_clip_alpha.sv */
// ----------------------------------------------------------------------------
// glyph_blit_clip_alpha
// Antialiased glyph blitter with per-pixel screen clipping.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one glyph coverage byte per transaction, rows padded to a
//   multiple of four bytes; tuser marks the first byte of a glyph, which
//   latches the pen point, origin offset and box width.
//   m_axis carries one pixel write per kept byte. Padding, zero levels, rows
//   past the box and off-screen pixels produce no transaction.
//   The cfg port writes screen width, screen height and pen colour; write it
//   only while no byte is in flight.
// Timing:
//   Position and result registers: a kept byte passes through the position
//   register and then the result register before it is presented on m_axis.
//   One byte is taken every cycle while m_axis does not stall.
// Reset:
//   Clears position state and both valid flags; registers return to
//   640 x 480 and an opaque white pen.
// Back-pressure:
//   While m_axis_tready is low with a result pending, the result register
//   and the position register both hold; s_axis_tready drops once the
//   position register is occupied as well.
// ----------------------------------------------------------------------------
module glyph_blit_clip_alpha (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pen_x, pen_y, origin_dx, origin_dy, box_width, box_height, level, zero pad
  input  logic [gblit_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // glyph_first
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [gblit_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [gblit_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gblit_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gblit_pkg::*;

  gblit_cfg_t cfg;
  gblit_pos_t pos;
  logic       pos_valid;
  logic       adv;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  logic [31:0] pixel_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= RST_SCREEN_WIDTH;
      cfg.screen_height <= RST_SCREEN_HEIGHT;
      cfg.pen_color     <= RST_PEN_COLOR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[10:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[10:0];
        REG_PEN_COLOR:     cfg.pen_color     <= cfg_data;
        default: ;
      endcase
    end
  end

  gblit_track u_track (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_first      (s_axis_tuser[0]),
    .in_pen_x      (s_axis_tdata[15:0]),
    .in_pen_y      (s_axis_tdata[31:16]),
    .in_origin_dx  (s_axis_tdata[39:32]),
    .in_origin_dy  (s_axis_tdata[47:40]),
    .in_box_width  (s_axis_tdata[54:48]),
    .in_box_height (s_axis_tdata[61:55]),
    .in_level      (s_axis_tdata[68:62]),
    .adv           (adv),
    .pos_valid     (pos_valid),
    .pos           (pos)
  );

  gblit_shade u_shade (
    .clk         (clk),
    .rst         (rst),
    .pos_valid   (pos_valid),
    .pos         (pos),
    .cfg         (cfg),
    .out_ready   (m_axis_tready),
    .adv         (adv),
    .out_valid   (m_axis_tvalid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color)
  );

  assign m_axis_tdata = {4'd0, pixel_color, pixel_y, pixel_x};

endmodule
